[hdl/i8wmv_pkg.sv]
`timescale 1ns / 1ps

package i8wmv_pkg;

	// lanes are fixed by the eight bytes of one weight beat
	localparam int LANES    = 8;
	localparam int LANE_SH  = 3;

	localparam int ACT_W    = 16;
	localparam int WGT_W    = 8;
	localparam int PROD_W   = ACT_W + WGT_W;
	localparam int SUM_W    = PROD_W + LANE_SH;
	localparam int ACC_W    = 40;
	localparam int SCALE_W  = 16;
	localparam int P_W      = ACC_W + SCALE_W;
	localparam int RND_SH   = 16;
	localparam int RND_W    = P_W + 1 - RND_SH;
	localparam int RES_W    = 32;
	localparam int ROW_W    = 16;
	localparam int IDX_W    = 12;

	localparam int VLEN_W   = 13;
	localparam int RCNT_W   = 17;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 17;

	localparam logic [VLEN_W-1:0] VLEN_RST = VLEN_W'(4096);
	localparam logic [RCNT_W-1:0] RCNT_RST = RCNT_W'(16384);

	localparam int DEF_MAX_K    = 4096;
	localparam int DEF_MAX_ROWS = 65536;

	localparam logic [CFG_IDX_W-1:0] REG_VLEN = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_RCNT = 1'b1;

	localparam logic KIND_ACT   = 1'b0;
	localparam logic KIND_CHUNK = 1'b1;

	typedef struct packed {
		logic                      kind;
		logic [IDX_W-1:0]          act_index;
		logic signed [ACT_W-1:0]   act_value;
		logic [LANES*WGT_W-1:0]    weight_chunk;
		logic signed [SCALE_W-1:0] row_scale;
	} item_t;

	typedef struct packed {
		logic signed [RES_W-1:0] row_result;
		logic [ROW_W-1:0]        row_index;
		logic                    last_row;
		logic                    saturated;
	} result_t;

	// per-beat bookkeeping that rides along with the lane data
	typedef struct packed {
		logic                      is_final;
		logic signed [SCALE_W-1:0] scale;
		logic [ROW_W-1:0]          row_index;
		logic                      last_row;
	} meta_t;

	// stage advance enables and the valid bits the merge stage needs
	typedef struct packed {
		logic en3;
		logic en4;
		logic en5;
		logic en_out;
		logic v3;
		logic v5;
	} adv_t;

endpackage

[hdl/i8wmv_act_store.sv]
`timescale 1ns / 1ps

module i8wmv_act_store #(
	parameter int DEPTH = 512,
	parameter int AW    = 9
) (
	input  logic                                                     clk,
	input  logic                                                     wr_en,
	input  logic [i8wmv_pkg::LANE_SH-1:0]                            wr_bank,
	input  logic [AW-1:0]                                            wr_row,
	input  logic [i8wmv_pkg::ACT_W-1:0]                              wr_data,
	input  logic                                                     rd_en,
	input  logic [AW-1:0]                                            rd_row,
	output logic [i8wmv_pkg::LANES-1:0][i8wmv_pkg::ACT_W-1:0]        rd_data
);

	// one bank per lane: element k lives in bank k mod LANES, row k / LANES
	for (genvar b = 0; b < i8wmv_pkg::LANES; b++) begin : g_bank
		logic [i8wmv_pkg::ACT_W-1:0] mem [DEPTH];
		logic [i8wmv_pkg::ACT_W-1:0] rd_q;

		always_ff @(posedge clk) begin
			if (wr_en && wr_bank == i8wmv_pkg::LANE_SH'(b)) begin
				mem[wr_row] <= wr_data;
			end
			if (rd_en) begin
				rd_q <= mem[rd_row];
			end
		end

		assign rd_data[b] = rd_q;
	end

endmodule

[hdl/i8wmv_lane.sv]
`timescale 1ns / 1ps

module i8wmv_lane (
	input  logic                                 clk,
	input  logic                                 en,
	input  logic                                 ok,
	input  logic signed [i8wmv_pkg::ACT_W-1:0]   act,
	input  logic signed [i8wmv_pkg::WGT_W-1:0]   weight,
	output logic signed [i8wmv_pkg::PROD_W-1:0]  prod_s2
);

	// drop lanes past the vector end, whatever the store holds there
	always_ff @(posedge clk) begin
		if (en) begin
			if (ok) begin
				prod_s2 <= act * weight;
			end else begin
				prod_s2 <= '0;
			end
		end
	end

endmodule

[hdl/i8wmv_merge.sv]
`timescale 1ns / 1ps

module i8wmv_merge (
	input  logic                                                  clk,
	input  logic                                                  arst_n,
	input  i8wmv_pkg::adv_t                                       adv,
	input  logic [i8wmv_pkg::LANES-1:0][i8wmv_pkg::PROD_W-1:0]    prod_s2,
	input  i8wmv_pkg::meta_t                                      meta_s2,
	output logic                                                  result_valid,
	output i8wmv_pkg::result_t                                    result
);

	logic signed [i8wmv_pkg::SUM_W-1:0]   sum;
	logic signed [i8wmv_pkg::SUM_W-1:0]   sum_s3;
	i8wmv_pkg::meta_t                     meta_s3;
	i8wmv_pkg::meta_t                     meta_s4;
	i8wmv_pkg::meta_t                     meta_s5;
	logic signed [i8wmv_pkg::ACC_W-1:0]   acc_q;
	logic signed [i8wmv_pkg::ACC_W-1:0]   acc_next;
	logic signed [i8wmv_pkg::ACC_W-1:0]   total_s4;
	logic signed [i8wmv_pkg::SCALE_W-1:0] scale_s4;
	logic signed [i8wmv_pkg::P_W-1:0]     p_s5;
	logic [i8wmv_pkg::P_W:0]              q;
	logic [i8wmv_pkg::RND_W-1:0]          r;
	logic                                 sat_hi;
	logic                                 sat_lo;
	logic                                 result_valid_q;

	always_comb begin
		sum = '0;
		for (int l = 0; l < i8wmv_pkg::LANES; l++) begin
			sum = sum + i8wmv_pkg::SUM_W'($signed(prod_s2[l]));
		end
	end

	assign acc_next = acc_q + i8wmv_pkg::ACC_W'(sum_s3);
	assign scale_s4 = meta_s4.scale;

	// add half an LSB, then floor by the arithmetic shift
	assign q = {p_s5[i8wmv_pkg::P_W-1], p_s5} + (i8wmv_pkg::P_W+1)'(32768);
	assign r = q[i8wmv_pkg::P_W:i8wmv_pkg::RND_SH];
	assign sat_hi = !r[i8wmv_pkg::RND_W-1] && (|r[i8wmv_pkg::RND_W-2:i8wmv_pkg::RES_W-1]);
	assign sat_lo = r[i8wmv_pkg::RND_W-1] && !(&r[i8wmv_pkg::RND_W-2:i8wmv_pkg::RES_W-1]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q          <= '0;
			result_valid_q <= 1'b0;
		end else begin
			if (adv.en4 && adv.v3) begin
				acc_q <= meta_s3.is_final ? '0 : acc_next;
			end
			if (adv.en_out) begin
				result_valid_q <= adv.v5 && meta_s5.is_final;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv.en3) begin
			sum_s3  <= sum;
			meta_s3 <= meta_s2;
		end
		if (adv.en4) begin
			total_s4 <= acc_next;
			meta_s4  <= meta_s3;
		end
		if (adv.en5) begin
			p_s5    <= total_s4 * scale_s4;
			meta_s5 <= meta_s4;
		end
		if (adv.en_out) begin
			priority if (sat_hi) begin
				result.row_result <= {1'b0, {(i8wmv_pkg::RES_W-1){1'b1}}};
			end else if (sat_lo) begin
				result.row_result <= {1'b1, {(i8wmv_pkg::RES_W-1){1'b0}}};
			end else begin
				result.row_result <= r[i8wmv_pkg::RES_W-1:0];
			end
			result.saturated <= sat_hi || sat_lo;
			result.row_index <= meta_s5.row_index;
			result.last_row  <= meta_s5.last_row;
		end
	end

	assign result_valid = result_valid_q;

endmodule

[hdl/int8_weight_matrix_vector_product.sv]
`timescale 1ns / 1ps
// channel   direction  handshake                     beat
// item      in         item_valid / item_stall       item_t: activation load or weight chunk
// result    out        result_valid / result_stall   result_t: one scaled row
// cfg       in         cfg_write                     cfg_index selects register, cfg_data
//
// One item per cycle while item_stall is low. A row result leaves after its final chunk
// is taken, through the five register stages: store read, lane multiply, lane sum, row
// accumulate, scale multiply, then the output register.
// arst_n clears the counters, the accumulator, the stage valids and the registers to
// their defaults; the activation banks are not cleared and must be loaded before use.
// A stalled result holds; stages behind it keep filling until no bubble is left.

module int8_weight_matrix_vector_product #(
	parameter int MAX_K    = i8wmv_pkg::DEF_MAX_K,
	parameter int MAX_ROWS = i8wmv_pkg::DEF_MAX_ROWS
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 item_valid,
	output logic                                 item_stall,
	input  i8wmv_pkg::item_t                     item,
	output logic                                 result_valid,
	input  logic                                 result_stall,
	output i8wmv_pkg::result_t                   result,
	input  logic                                 cfg_write,
	input  logic [i8wmv_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [i8wmv_pkg::CFG_DATA_W-1:0]     cfg_data
);

	localparam int BANK_DEPTH = (MAX_K + i8wmv_pkg::LANES - 1) / i8wmv_pkg::LANES;
	localparam int BANK_AW    = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
	localparam int POS_W      = $clog2(MAX_K + 2 * i8wmv_pkg::LANES) + 1;
	localparam int WIX_W      = (POS_W > i8wmv_pkg::IDX_W) ? POS_W : i8wmv_pkg::IDX_W;
	localparam int CNT_W      = $clog2(MAX_ROWS);
	localparam int CMP_W      = (CNT_W > i8wmv_pkg::RCNT_W) ? CNT_W : i8wmv_pkg::RCNT_W;

	logic [i8wmv_pkg::VLEN_W-1:0] vlen_q;
	logic [i8wmv_pkg::RCNT_W-1:0] rcnt_q;
	logic [BANK_AW-1:0]           chunk_q;
	logic [CNT_W-1:0]             row_q;

	logic en1, en2, en3, en4, en5, en_out;
	logic v1, v2, v3, v4, v5;
	logic accept, act_wr, chunk_take;

	logic [POS_W-1:0]             vlen_ext;
	logic [POS_W-1:0]             len;
	logic [POS_W-1:0]             base;
	logic                         is_final;
	logic [i8wmv_pkg::LANES-1:0]  lane_ok;
	logic                         last;
	logic [WIX_W-1:0]             wr_idx;
	logic                         wr_ok;

	logic [i8wmv_pkg::LANES-1:0]                               ok_s1;
	logic [i8wmv_pkg::LANES*i8wmv_pkg::WGT_W-1:0]              w_s1;
	logic [i8wmv_pkg::LANES-1:0][i8wmv_pkg::ACT_W-1:0]         act_s1;
	i8wmv_pkg::meta_t                                          meta_s1;
	i8wmv_pkg::meta_t                                          meta_s2;
	logic [i8wmv_pkg::LANES-1:0][i8wmv_pkg::PROD_W-1:0]        prod_s2;
	i8wmv_pkg::adv_t                                           adv;

	// each stage moves when it is empty or the next one moves
	assign en_out = !result_valid || !result_stall;
	assign en5    = !v5 || en_out;
	assign en4    = !v4 || en5;
	assign en3    = !v3 || en4;
	assign en2    = !v2 || en3;
	assign en1    = !v1 || en2;

	assign item_stall = !en1;
	assign accept     = item_valid && en1;
	assign act_wr     = accept && item.kind == i8wmv_pkg::KIND_ACT;
	assign chunk_take = accept && item.kind == i8wmv_pkg::KIND_CHUNK;

	assign vlen_ext = POS_W'(vlen_q);
	assign len      = (vlen_ext > POS_W'(MAX_K)) ? POS_W'(MAX_K) : vlen_ext;
	assign base     = POS_W'(chunk_q) << i8wmv_pkg::LANE_SH;
	assign is_final = (base + POS_W'(i8wmv_pkg::LANES)) >= len;

	always_comb begin
		for (int l = 0; l < i8wmv_pkg::LANES; l++) begin
			lane_ok[l] = (base + POS_W'(l)) < len;
		end
	end

	assign last = (rcnt_q != '0) && (CMP_W'(row_q) == CMP_W'(rcnt_q) - CMP_W'(1));

	assign wr_idx = WIX_W'(item.act_index);
	assign wr_ok  = wr_idx < WIX_W'(MAX_K);

	i8wmv_act_store #(
		.DEPTH (BANK_DEPTH),
		.AW    (BANK_AW)
	) u_store (
		.clk     (clk),
		.wr_en   (act_wr && wr_ok),
		.wr_bank (item.act_index[i8wmv_pkg::LANE_SH-1:0]),
		.wr_row  (wr_idx[BANK_AW+i8wmv_pkg::LANE_SH-1:i8wmv_pkg::LANE_SH]),
		.wr_data (item.act_value),
		.rd_en   (en1),
		.rd_row  (chunk_q),
		.rd_data (act_s1)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vlen_q  <= i8wmv_pkg::VLEN_RST;
			rcnt_q  <= i8wmv_pkg::RCNT_RST;
			chunk_q <= '0;
			row_q   <= '0;
			v1      <= 1'b0;
			v2      <= 1'b0;
			v3      <= 1'b0;
			v4      <= 1'b0;
			v5      <= 1'b0;
		end else begin
			if (cfg_write) begin
				unique case (cfg_index)
					i8wmv_pkg::REG_VLEN: begin
						vlen_q <= i8wmv_pkg::VLEN_W'(cfg_data);
					end
					i8wmv_pkg::REG_RCNT: begin
						rcnt_q <= i8wmv_pkg::RCNT_W'(cfg_data);
					end
					default: begin
					end
				endcase
			end
			if (chunk_take) begin
				if (is_final) begin
					chunk_q <= '0;
					// wrap on the configured row count, else on the counter range
					if (last || row_q == CNT_W'(MAX_ROWS - 1)) begin
						row_q <= '0;
					end else begin
						row_q <= row_q + CNT_W'(1);
					end
				end else begin
					chunk_q <= chunk_q + BANK_AW'(1);
				end
			end
			if (en1) v1 <= chunk_take;
			if (en2) v2 <= v1;
			if (en3) v3 <= v2;
			if (en4) v4 <= v3;
			if (en5) v5 <= v4;
		end
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			ok_s1             <= lane_ok;
			w_s1              <= item.weight_chunk;
			meta_s1.is_final  <= is_final;
			meta_s1.scale     <= item.row_scale;
			meta_s1.row_index <= i8wmv_pkg::ROW_W'(row_q);
			meta_s1.last_row  <= last;
		end
		if (en2) begin
			meta_s2 <= meta_s1;
		end
	end

	for (genvar l = 0; l < i8wmv_pkg::LANES; l++) begin : g_lane
		i8wmv_lane u_lane (
			.clk     (clk),
			.en      (en2),
			.ok      (ok_s1[l]),
			.act     (act_s1[l]),
			.weight  (w_s1[l*i8wmv_pkg::WGT_W +: i8wmv_pkg::WGT_W]),
			.prod_s2 (prod_s2[l])
		);
	end

	assign adv.en3    = en3;
	assign adv.en4    = en4;
	assign adv.en5    = en5;
	assign adv.en_out = en_out;
	assign adv.v3     = v3;
	assign adv.v5     = v5;

	i8wmv_merge u_merge (
		.clk          (clk),
		.arst_n       (arst_n),
		.adv          (adv),
		.prod_s2      (prod_s2),
		.meta_s2      (meta_s2),
		.result_valid (result_valid),
		.result       (result)
	);

endmodule

[test/tb_int8_weight_matrix_vector_product.sv]
`timescale 1ns / 1ps

module tb_int8_weight_matrix_vector_product;
	import i8wmv_pkg::*;

	localparam int LIMIT       = 200000;
	localparam int HOLD_CYCLES = 300;
	localparam int DRAIN       = 12;
	localparam int PHASE_BEATS = 134;
	localparam int FILL_K      = 256;

	typedef enum logic [1:0] {STEP_CFG, STEP_ITEM, STEP_ITEM_EXP} step_kind_e;

	typedef struct {
		step_kind_e             op;
		logic [CFG_IDX_W-1:0]   reg_idx;
		int unsigned            reg_val;
		item_t                  beat;
		result_t                want;
	} step_t;

	logic    clk;
	logic    arst_n;
	logic    item_valid;
	logic    item_stall;
	item_t   item;
	logic    result_valid;
	logic    result_stall;
	result_t result;
	logic                  cfg_write;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	// predictor state
	logic signed [ACT_W-1:0] act_copy [DEF_MAX_K];
	logic signed [ACC_W-1:0] acc_sum = '0;
	int                      chunk_no = 0;
	int                      row_no = 0;
	logic [VLEN_W-1:0]       vlen = VLEN_RST;
	logic [RCNT_W-1:0]       rcnt = RCNT_RST;

	result_t rows_due [$];
	result_t head;
	step_t   directed_steps [$];

	int errors = 0;
	int rows_checked = 0;
	int sat_seen = 0;
	int last_seen = 0;
	int n_loads = 0;
	int n_chunks = 0;
	int n_writes = 0;
	int cycle_count = 0;
	int unsigned burst_left = 0;
	bit tx_bursty = 1'b1;
	bit hold_req = 1'b0;

	int8_weight_matrix_vector_product dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.cfg_write    (cfg_write),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic logic signed [ACT_W-1:0] rand_q412();
		case ($urandom_range(0, 7))
			0: return 16'sh7FFF;
			1: return 16'sh8000;
			2: return 16'sh1000;
			default: return ACT_W'($urandom);
		endcase
	endfunction

	function automatic logic [LANES*WGT_W-1:0] rand_weights();
		case ($urandom_range(0, 7))
			0: return {LANES{8'h80}};
			1: return {LANES{8'h7F}};
			default: return {$urandom, $urandom};
		endcase
	endfunction

	// unused fields carry noise so every bit toggles
	function automatic item_t load_beat(input logic [IDX_W-1:0] idx,
			input logic signed [ACT_W-1:0] val);
		item_t b;
		b.kind = KIND_ACT;
		b.act_index = idx;
		b.act_value = val;
		b.weight_chunk = {$urandom, $urandom};
		b.row_scale = SCALE_W'($urandom);
		return b;
	endfunction

	function automatic item_t chunk_beat(input logic [LANES*WGT_W-1:0] w,
			input logic signed [SCALE_W-1:0] scale);
		item_t b;
		b.kind = KIND_CHUNK;
		b.act_index = IDX_W'($urandom);
		b.act_value = ACT_W'($urandom);
		b.weight_chunk = w;
		b.row_scale = scale;
		return b;
	endfunction

	function automatic result_t row_out(input int r, input int idx, input bit is_last,
			input bit sat);
		result_t o;
		o.row_result = RES_W'(r);
		o.row_index = ROW_W'(idx);
		o.last_row = is_last;
		o.saturated = sat;
		return o;
	endfunction

	function automatic step_t cfg_step(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
		step_t s;
		s.op = STEP_CFG;
		s.reg_idx = idx;
		s.reg_val = val;
		s.beat = '0;
		s.want = '0;
		return s;
	endfunction

	function automatic step_t beat_step(input item_t b);
		step_t s;
		s = cfg_step(REG_VLEN, 0);
		s.op = STEP_ITEM;
		s.beat = b;
		return s;
	endfunction

	function automatic step_t checked_step(input item_t b, input result_t w);
		step_t s;
		s = beat_step(b);
		s.op = STEP_ITEM_EXP;
		s.want = w;
		return s;
	endfunction

	// advance the predictor by one accepted beat; returns 1 when a row completes
	function automatic bit predict_row(input item_t b, output result_t r);
		int len;
		int pos;
		longint p;
		longint q;
		bit sat;
		bit is_last;
		logic signed [WGT_W-1:0] w;
		r = '0;
		len = (int'(vlen) > DEF_MAX_K) ? DEF_MAX_K : int'(vlen);
		if (b.kind == KIND_ACT) begin
			act_copy[b.act_index] = b.act_value;
			return 1'b0;
		end
		for (int lane = 0; lane < LANES; lane++) begin
			pos = chunk_no * LANES + lane;
			w = b.weight_chunk[lane*WGT_W +: WGT_W];
			if (pos < len)
				acc_sum = acc_sum + longint'(act_copy[pos]) * longint'(w);
		end
		if (chunk_no * LANES + LANES < len) begin
			chunk_no++;
			return 1'b0;
		end
		// Q.24 product, then shifted right by 16 bits down to Q.8 with round half up
		p = longint'(acc_sum) * longint'(b.row_scale);
		q = (p + 64'sd32768) >>> RND_SH;
		sat = 1'b0;
		if (q > 64'sd2147483647) begin
			q = 64'sd2147483647;
			sat = 1'b1;
		end else if (q < -64'sd2147483648) begin
			q = -64'sd2147483648;
			sat = 1'b1;
		end
		is_last = (rcnt != '0) && (row_no == int'(rcnt) - 1);
		r.row_result = RES_W'(q);
		r.row_index = ROW_W'(row_no);
		r.last_row = is_last;
		r.saturated = sat;
		acc_sum = '0;
		chunk_no = 0;
		row_no = is_last ? 0 : (row_no + 1) % DEF_MAX_ROWS;
		return 1'b1;
	endfunction

	task automatic push_item(input item_t beat, input bit fixed, input result_t want);
		int unsigned gap;
		result_t got;
		if (tx_bursty && burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap != 0) begin
				item_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		if (burst_left != 0)
			burst_left--;
		item_valid <= 1'b1;
		item <= beat;
		@(posedge clk);
		while (item_stall)
			@(posedge clk);
		if (beat.kind == KIND_ACT)
			n_loads++;
		else
			n_chunks++;
		if (predict_row(beat, got))
			rows_due.push_back(fixed ? want : got);
	endtask

	// drop valid, wait for every due row, then let loads still in flight settle
	task automatic settle();
		item_valid <= 1'b0;
		while (rows_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
		settle();
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= CFG_DATA_W'(val);
		@(posedge clk);
		cfg_write <= 1'b0;
		if (idx == REG_VLEN)
			vlen = VLEN_W'(val);
		else
			rcnt = RCNT_W'(val);
		n_writes++;
	endtask

	task automatic report_field(input string field, input longint want, input longint got);
		errors++;
		$display("%0t ns: %s expected %0d, got %0d", $time, field, want, got);
	endtask

	always @(posedge clk) begin
		if (arst_n && result_valid === 1'b1 && !result_stall) begin
			if (rows_due.size() == 0) begin
				errors++;
				$display("%0t ns: expected no row, got %0d index %0d", $time,
					result.row_result, result.row_index);
			end else begin
				head = rows_due.pop_front();
				rows_checked++;
				if (head.saturated)
					sat_seen++;
				if (head.last_row)
					last_seen++;
				if (result.row_result !== head.row_result)
					report_field("row_result", head.row_result, result.row_result);
				if (result.row_index !== head.row_index)
					report_field("row_index", head.row_index, result.row_index);
				if (result.last_row !== head.last_row)
					report_field("last_row", head.last_row, result.last_row);
				if (result.saturated !== head.saturated)
					report_field("saturated", head.saturated, result.saturated);
			end
		end
	end

	// receiver: stall density changes per segment, plus one long hold on request
	initial begin
		int unsigned seg;
		int unsigned pct;
		seg = 0;
		pct = 0;
		result_stall <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				result_stall <= 1'b1;
				for (int k = 1; k < HOLD_CYCLES; k++)
					@(posedge clk);
			end else begin
				if (seg == 0) begin
					seg = $urandom_range(16, 200);
					case ($urandom_range(0, 3))
						0: pct = 0;
						1: pct = 20;
						2: pct = 50;
						default: pct = 85;
					endcase
				end
				seg--;
				result_stall <= ($urandom_range(0, 99) < pct);
			end
		end
	end

	initial begin
		while (cycle_count < LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("timed out after %0d cycles with %0d rows due", cycle_count, rows_due.size());
		$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		int unsigned phase_vlen [8];
		int unsigned phase_rcnt [8];
		phase_vlen = '{1, 8, 9, 16, 23, 64, 200, 4};
		phase_rcnt = '{1, 3, 65536, 2, 131071, 5, 7, 0};
		arst_n <= 1'b0;
		item_valid <= 1'b0;
		item <= '0;
		cfg_write <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// one-element vector: extremes, rounding at the half, row wrap on last
		directed_steps.push_back(cfg_step(REG_VLEN, 1));
		directed_steps.push_back(cfg_step(REG_RCNT, 2));
		directed_steps.push_back(beat_step(load_beat(0, 16'sh1000)));
		directed_steps.push_back(checked_step(chunk_beat(64'hFFFF_FFFF_FFFF_FF7F, 16'sh1000),
			row_out(32512, 0, 0, 0)));
		directed_steps.push_back(checked_step(chunk_beat(64'h7F7F_7F7F_7F7F_7F80, 16'sh1000),
			row_out(-32768, 1, 1, 0)));
		directed_steps.push_back(beat_step(load_beat(0, 16'sh0008)));
		directed_steps.push_back(checked_step(chunk_beat(64'h0000_0000_0000_0001, 16'sh1000),
			row_out(1, 0, 0, 0)));
		directed_steps.push_back(checked_step(chunk_beat(64'h0000_0000_0000_0001, 16'shF000),
			row_out(0, 1, 1, 0)));
		// zero length: every weight beat closes a row of zero
		directed_steps.push_back(cfg_step(REG_VLEN, 0));
		directed_steps.push_back(checked_step(chunk_beat(64'hFFFF_FFFF_FFFF_FFFF, 16'sh7FFF),
			row_out(0, 0, 0, 0)));
		directed_steps.push_back(cfg_step(REG_RCNT, 0));
		directed_steps.push_back(checked_step(chunk_beat(64'h8080_8080_8080_8080, 16'sh8000),
			row_out(0, 1, 0, 0)));
		// two beats per row, second one partly past the vector
		directed_steps.push_back(cfg_step(REG_VLEN, 10));
		directed_steps.push_back(cfg_step(REG_RCNT, 131071));
		directed_steps.push_back(beat_step(load_beat(1, 16'sh7FFF)));
		directed_steps.push_back(beat_step(load_beat(2, 16'sh8000)));
		directed_steps.push_back(beat_step(load_beat(3, 16'shFFFF)));
		directed_steps.push_back(beat_step(load_beat(4, 16'sh0001)));
		directed_steps.push_back(beat_step(load_beat(5, 16'sh1000)));
		directed_steps.push_back(beat_step(load_beat(6, 16'shF000)));
		directed_steps.push_back(beat_step(load_beat(7, 16'sh7FFF)));
		directed_steps.push_back(beat_step(load_beat(8, 16'sh8000)));
		directed_steps.push_back(beat_step(load_beat(9, 16'sh0800)));
		directed_steps.push_back(beat_step(load_beat(4095, 16'sh5A5A)));
		directed_steps.push_back(beat_step(chunk_beat(64'h7F80_017F_80FF_7F80, 16'sh1234)));
		// rewrite mid-row: the closing beat must see the new value
		directed_steps.push_back(beat_step(load_beat(8, 16'sh7FFF)));
		directed_steps.push_back(beat_step(chunk_beat(64'h0102_0304_0506_8081, 16'sh8000)));

		foreach (directed_steps[i]) begin
			case (directed_steps[i].op)
				STEP_CFG: write_reg(directed_steps[i].reg_idx, directed_steps[i].reg_val);
				STEP_ITEM: push_item(directed_steps[i].beat, 1'b0, '0);
				default: push_item(directed_steps[i].beat, 1'b1, directed_steps[i].want);
			endcase
		end

		// fill the part of the store that the random phases read
		for (int i = 0; i < FILL_K; i++)
			push_item(load_beat(IDX_W'(i), rand_q412()), 1'b0, '0);

		for (int ph = 0; ph < 8; ph++) begin
			write_reg(REG_VLEN, phase_vlen[ph]);
			write_reg(REG_RCNT, phase_rcnt[ph]);
			tx_bursty = (ph != 3);
			if (ph == 0)
				hold_req = 1'b1;
			for (int i = 0; i < PHASE_BEATS; i++) begin
				if ($urandom_range(0, 99) < 15)
					push_item(load_beat(IDX_W'($urandom_range(0, FILL_K - 1)), rand_q412()),
						1'b0, '0);
				else
					push_item(chunk_beat(rand_weights(), rand_q412()), 1'b0, '0);
			end
		end
		tx_bursty = 1'b1;

		settle();
		$display("covered %0d beats in (%0d activation loads, %0d weight beats), %0d writes",
			n_loads + n_chunks, n_loads, n_chunks, n_writes);
		$display("checked %0d rows, %0d saturated, %0d last-row flags, %0d mismatches",
			rows_checked, sat_seen, last_seen, errors);
		if (errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

[files.f]
hdl/i8wmv_pkg.sv
hdl/i8wmv_act_store.sv
hdl/i8wmv_lane.sv
hdl/i8wmv_merge.sv
hdl/int8_weight_matrix_vector_product.sv
test/tb_int8_weight_matrix_vector_product.sv
